[rtl/mbps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants for the masked byte pattern search
// Request structs, configuration register indexes and window types.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // longest pattern and the window that holds it
    localparam int PATTERN_MAX = 16;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RESULT_OFFSET  = 3'd4;

    // byte 0 is the oldest window byte / first pattern byte
    typedef logic [PATTERN_MAX-1:0][7:0] byte_vec_t;

    // one scanned byte
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] byte_address;
        logic        region_last;
    } in_item_t;

    // one search result
    typedef struct packed {
        logic        found;
        logic [31:0] match_address;
    } out_item_t;

    // pattern settings seen by the compare unit
    typedef struct packed {
        byte_vec_t              pattern;
        logic [PATTERN_MAX-1:0] care_mask;
        logic [LEN_W-1:0]       eff_len;
    } match_cfg_t;

endpackage

[rtl/mbps_match.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbps_match: masked window compare
// Compares the newest eff_len window bytes with the pattern, all lanes at once.
// ----------------------------------------------------------------------------
module mbps_match (
    input  mbps_pkg::byte_vec_t        window,
    input  logic [mbps_pkg::LEN_W-1:0] fill,
    input  mbps_pkg::match_cfg_t       cfg,
    output logic                       hit
);
    import mbps_pkg::*;

    localparam int IDX_W = $clog2(PATTERN_MAX);

    logic [PATTERN_MAX-1:0] lane_ok;

    // one lane per pattern byte; lanes past the length always pass
    always_comb begin
        logic [LEN_W:0] pos;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pos = (LEN_W + 1)'(PATTERN_MAX) - {1'b0, cfg.eff_len} + (LEN_W + 1)'(i);
            if ((LEN_W)'(i) >= cfg.eff_len || !cfg.care_mask[i]) begin
                lane_ok[i] = 1'b1;
            end else begin
                lane_ok[i] = (window[pos[IDX_W-1:0]] == cfg.pattern[i]);
            end
        end
    end

    // enough bytes seen and every lane agrees
    assign hit = (fill >= cfg.eff_len) && (&lane_ok);

endmodule

[rtl/masked_byte_pattern_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_search: masked byte signature scan
// Finds the first masked pattern match in a byte region and reports its address.
// ----------------------------------------------------------------------------
// One byte of the region is taken per request and the block sustains one byte
// per clock while m_ready keeps the output register free: the request is
// registered, then once the output side has room the byte is shifted into a
// 16-byte window, all pattern lanes are compared in parallel and the result lands
// in an output register that drives m_valid. While that result waits on m_ready,
// one more byte can sit in the input register before s_ready drops. A region
// gives at most one result: found=1 with the match start address plus
// result_offset on the first match (the rest of the region is then dropped
// silently), or found=0 with address 0 on the region's last byte if nothing
// matched. Configuration is written through cfg_wr_en, cfg_index and cfg_data;
// the user must write it only while no byte is in flight, which the block itself
// does not enforce.
module masked_byte_pattern_search (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  mbps_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output mbps_pkg::out_item_t                m_data,
    input  logic                               cfg_wr_en,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mbps_pkg::*;

    // configuration registers
    logic [63:0]            pattern_low_reg;
    logic [63:0]            pattern_high_reg;
    logic [PATTERN_MAX-1:0] care_mask_reg;
    logic [4:0]             pattern_length_reg;
    logic [31:0]            result_offset_reg;

    // input stage
    logic     in_valid_reg;
    in_item_t in_item_reg;

    // scan state
    byte_vec_t        window_reg;
    logic [LEN_W-1:0] fill_reg;
    logic             match_reported_reg;

    // output stage
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic             advance;
    logic             active;
    logic             hit;
    logic             produce;
    byte_vec_t        window_next;
    logic [LEN_W-1:0] fill_next;
    logic [LEN_W-1:0] eff_len;
    logic [31:0]      start_addr;
    match_cfg_t       match_cfg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            care_mask_reg      <= '1;
            pattern_length_reg <= 5'd1;
            result_offset_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                REG_CARE_MASK:      care_mask_reg      <= cfg_data[PATTERN_MAX-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[4:0];
                REG_RESULT_OFFSET:  result_offset_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // length clamped to 1..PATTERN_MAX
    always_comb begin
        if (pattern_length_reg == '0) begin
            eff_len = (LEN_W)'(1);
        end else if (pattern_length_reg > 5'(PATTERN_MAX)) begin
            eff_len = (LEN_W)'(PATTERN_MAX);
        end else begin
            eff_len = (LEN_W)'(pattern_length_reg);
        end
    end

    assign match_cfg.pattern   = {pattern_high_reg, pattern_low_reg};
    assign match_cfg.care_mask = care_mask_reg;
    assign match_cfg.eff_len   = eff_len;

    // handshake: the input register moves on when the output side has room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // shift the new byte in as the newest window entry
    assign window_next = {in_item_reg.data_byte, window_reg[PATTERN_MAX-1:1]};
    assign fill_next   = (fill_reg == (LEN_W)'(PATTERN_MAX)) ? fill_reg
                                                             : fill_reg + 1'b1;

    mbps_match u_match (
        .window (window_next),
        .fill   (fill_next),
        .cfg    (match_cfg),
        .hit    (hit)
    );

    assign active     = !match_reported_reg;
    assign produce    = active && (hit || in_item_reg.region_last);
    assign start_addr = in_item_reg.byte_address - 32'(eff_len - 1'b1) + result_offset_reg;

    // scan state update, cleared at the end of each region
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg         <= '0;
            fill_reg           <= '0;
            match_reported_reg <= 1'b0;
        end else if (advance) begin
            if (in_item_reg.region_last) begin
                window_reg         <= '0;
                fill_reg           <= '0;
                match_reported_reg <= 1'b0;
            end else if (active) begin
                window_reg <= window_next;
                fill_reg   <= fill_next;
                if (hit) begin
                    match_reported_reg <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && produce) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && produce) begin
            out_item_reg.found         <= hit;
            out_item_reg.match_address <= hit ? start_addr : '0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for masked_byte_pattern_search
// Drives byte regions with random sender gaps and receiver stalls, and predicts
// every search report from a shadow copy of the window and the settings. Each
// report is checked field by field, in order, as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
    import mbps_pkg::*;

    localparam int LATENCY        = 2;
    localparam int SETTLE_CYCLES  = LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BYTES   = 1750;
    localparam int PHASE_BYTES    = 150;

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKE} rx_mode_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    masked_byte_pattern_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow settings
    logic [63:0] pat_lo;
    logic [63:0] pat_hi;
    logic [15:0] care;
    logic [4:0]  plen;
    logic [31:0] offset;

    // shadow scan state
    logic [7:0] window [PATTERN_MAX];
    int         fill;
    bit         reported;

    out_item_t pending_reports[$];

    int errors        = 0;
    int hits_seen     = 0;
    int misses_seen   = 0;
    int regions_sent  = 0;
    int scanned_bytes = 0;
    int sent_bytes    = 0;
    int cfg_writes    = 0;
    int burst_left    = 0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] pattern_at(int i);
        logic [127:0] both;
        both = {pat_hi, pat_lo};
        return both[i*8 +: 8];
    endfunction

    // zero and oversize lengths are clamped
    function automatic int active_length();
        int n;
        n = plen;
        if (n == 0) n = 1;
        if (n > PATTERN_MAX) n = PATTERN_MAX;
        return n;
    endfunction

    function automatic void clear_window();
        foreach (window[i]) window[i] = 8'h00;
        fill     = 0;
        reported = 1'b0;
    endfunction

    // shift one byte into the shadow window and queue the report it causes;
    // returns 1 when the byte was scanned rather than dropped after a match
    function automatic bit predict_scan(in_item_t rq);
        int        n;
        bit        hit;
        bit        scanned;
        out_item_t r;
        scanned = !reported;
        if (!reported) begin
            n = active_length();
            for (int i = 0; i < PATTERN_MAX - 1; i++) window[i] = window[i+1];
            window[PATTERN_MAX-1] = rq.data_byte;
            if (fill < PATTERN_MAX) fill++;
            hit = (fill >= n);
            for (int i = 0; i < n; i++) begin
                if (care[i] && window[PATTERN_MAX-n+i] != pattern_at(i)) hit = 1'b0;
            end
            if (hit) begin
                r.found         = 1'b1;
                r.match_address = rq.byte_address - 32'(n - 1) + offset;
                pending_reports.push_back(r);
                reported = 1'b1;
            end else if (rq.region_last) begin
                r.found         = 1'b0;
                r.match_address = '0;
                pending_reports.push_back(r);
            end
        end
        if (rq.region_last) clear_window();
        return scanned;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin : check_reports
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected report", '0, m_data.match_address);
            end else begin
                want = pending_reports.pop_front();
                if (m_data.found !== want.found)
                    report_mismatch("found", 32'(want.found), 32'(m_data.found));
                if (m_data.match_address !== want.match_address)
                    report_mismatch("match_address", want.match_address,
                                    m_data.match_address);
                if (want.found) hits_seen++;
                else misses_seen++;
            end
        end
    end

    // receiver stalls, switching between several patterns
    initial begin : drive_ready
        rx_mode_t mode;
        int       mode_left;
        int       tick;
        mode      = RX_OPEN;
        mode_left = 0;
        tick      = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (mode_left == 0) begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (mode)
                RX_OPEN:     m_ready <= 1'b1;
                RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_ready <= (tick % 5) != 0;
                default:     m_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // watchdog on cycles with no request or report moving
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("timeout: %0d reports still pending", pending_reports.size());
        $display("masked_byte_pattern_search verification failed");
        $finish;
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            REG_PATTERN_LOW:    pat_lo = val;
            REG_PATTERN_HIGH:   pat_hi = val;
            REG_CARE_MASK:      care   = val[15:0];
            REG_PATTERN_LENGTH: plen   = val[4:0];
            REG_RESULT_OFFSET:  offset = val[31:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // all five registers; upper bits of the narrow ones carry noise
    task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [15:0] c,
                             logic [4:0] len, logic [31:0] off);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_CARE_MASK, {noise[63:16], c});
        write_reg(REG_PATTERN_LENGTH, {noise[63:5], len});
        write_reg(REG_RESULT_OFFSET, {noise[63:32], off});
    endtask

    // stop sending until every report is out and the pipeline is empty
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one request, with sender bursts and gaps
    task automatic send_byte(logic [7:0] d, logic [31:0] a, bit last);
        int       gap;
        in_item_t rq;
        rq.data_byte    = d;
        rq.byte_address = a;
        rq.region_last  = last;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 64);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = 1;
                2:       gap = $urandom_range(2, 4);
                default: gap = $urandom_range(5, 12);
            endcase
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= rq;
        do @(posedge aclk); while (!s_ready);
        sent_bytes++;
        if (predict_scan(rq)) scanned_bytes++;
        if (last) regions_sent++;
    endtask

    // random region, optionally with the pattern planted (and maybe spoiled)
    task automatic send_region(int len, logic [31:0] base, bit scattered,
                               int plant_at, bit spoil);
        logic [7:0] content[$];
        int         n;
        int         k;
        n = active_length();
        for (int i = 0; i < len; i++) content.push_back(8'($urandom_range(0, 255)));
        if (plant_at >= 0 && plant_at + n <= len) begin
            for (int i = 0; i < n; i++) begin
                if (care[i]) content[plant_at+i] = pattern_at(i);
            end
            if (spoil) begin
                k = $urandom_range(0, n - 1);
                content[plant_at+k] = ~pattern_at(k);
            end
        end
        for (int i = 0; i < len; i++)
            send_byte(content[i], scattered ? 32'($urandom) : base + 32'(i), i == len - 1);
    endtask

    // reset settings: one-byte zero pattern, every byte cared for
    task automatic test_default_config();
        send_byte(8'h5A, 32'h0000_1000, 1'b0);
        send_byte(8'h00, 32'h0000_1001, 1'b0);
        send_byte(8'hFF, 32'h0000_1002, 1'b1);
        send_byte(8'hFF, 32'hFFFF_FFFF, 1'b1);
        drain();
    endtask

    // full 16-byte pattern ending on the last byte, address and offset wrapping
    task automatic test_full_length_wrap();
        configure(64'hFF00_A55A_0123_4567, 64'h89AB_CDEF_00FF_7E81, 16'hFFFF, 5'd16,
                  32'hFFFF_FFFF);
        for (int i = 0; i < PATTERN_MAX; i++)
            send_byte(pattern_at(i), 32'hFFFF_FFF8 + 32'(i), i == PATTERN_MAX - 1);
        drain();
    endtask

    // zero length acts as one, oversize length acts as the maximum
    task automatic test_length_limits();
        configure(64'h0, 64'h0, 16'h0000, 5'd0, 32'h0000_0010);
        send_byte(8'h3C, 32'h8000_0000, 1'b1);
        drain();
        write_reg(REG_PATTERN_LENGTH, 64'd31);
        send_byte(8'h00, 32'h0000_0040, 1'b0);
        send_byte(8'hFF, 32'h0000_0041, 1'b1);
        drain();
    endtask

    // pattern rewritten between two bytes of one region
    task automatic test_reconfig_mid_region();
        configure(64'hAB, 64'h0, 16'hFFFF, 5'd1, 32'h0);
        send_byte(8'hCD, 32'h0000_0020, 1'b0);
        drain();
        write_reg(REG_PATTERN_LOW, 64'hCD);
        send_byte(8'hCD, 32'h0000_0021, 1'b1);
        drain();
    endtask

    task automatic random_config();
        logic [15:0] c;
        logic [4:0]  len;
        logic [31:0] off;
        case ($urandom_range(0, 4))
            0:       c = 16'hFFFF;
            1:       c = 16'h0000;
            default: c = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       len = 5'd0;
            1:       len = 5'($urandom_range(17, 31));
            2:       len = 5'd16;
            3:       len = 5'd1;
            default: len = 5'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 3))
            0:       off = 32'h0;
            1:       off = 32'hFFFF_FFFF;
            default: off = $urandom;
        endcase
        configure({$urandom, $urandom}, {$urandom, $urandom}, c, len, off);
    endtask

    // mostly well-formed regions with a planted pattern, some noise and near misses
    task automatic test_random_regions();
        int          target;
        int          phase_end;
        int          len;
        int          kind;
        int          plant_at;
        logic [31:0] base;
        target = sent_bytes + RANDOM_BYTES;
        while (sent_bytes < target) begin
            drain();
            random_config();
            phase_end = sent_bytes + PHASE_BYTES;
            while (sent_bytes < phase_end && sent_bytes < target) begin
                len  = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80)
                                                   : $urandom_range(1, 24);
                base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                                                   : $urandom;
                plant_at = ($urandom_range(0, 3) == 0) ? len - active_length()
                                                       : $urandom_range(0, len);
                kind = $urandom_range(0, 9);
                if (kind < 2) send_region(len, base, 1'b1, -1, 1'b0);
                else if (kind == 2) send_region(len, base, 1'b0, plant_at, 1'b1);
                else if (kind == 3) send_region(len, base, 1'b0, -1, 1'b0);
                else send_region(len, base, 1'b0, plant_at, 1'b0);
            end
        end
    endtask

    // main sequence
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pat_lo    = '0;
        pat_hi    = '0;
        care      = 16'hFFFF;
        plen      = 5'd1;
        offset    = '0;
        clear_window();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_config();
        test_full_length_wrap();
        test_length_limits();
        test_reconfig_mid_region();
        test_random_regions();
        drain();

        $display("run covered %0d regions, %0d bytes sent and %0d scanned, %0d register writes",
                 regions_sent, sent_bytes, scanned_bytes, cfg_writes);
        $display("checked %0d match reports and %0d no-match reports, %0d mismatches",
                 hits_seen, misses_seen, errors);
        if (errors == 0) begin
            $display("masked_byte_pattern_search verification clean");
        end else begin
            $display("masked_byte_pattern_search verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mbps_pkg.sv
rtl/mbps_match.sv
rtl/masked_byte_pattern_search.sv
test/tb_top.sv
